>>> rtl/core/bap_pkg.sv
// ----------------------------------------------------------------------------
// bap_pkg: shared types and constants of the block-average pixelate core
// Payload structs, configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bap_pkg;

	localparam int MAX_IMAGE_WIDTH_DEF = 2048;
	localparam int MAX_BLOCK_SIDE_DEF  = 64;
	localparam int MAX_IMAGE_HEIGHT    = 2048;
	localparam int ROW_W               = 11;
	localparam int COL_W               = 11;
	localparam int CFG_IDX_W           = 2;
	localparam int CFG_DATA_W          = 12;
	localparam int QUEUE_DEPTH         = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT = 2'd3;

	typedef struct packed {
		logic [7:0] pixel_blue;
		logic [7:0] pixel_green;
		logic [7:0] pixel_red;
	} pix_t;

	typedef struct packed {
		logic [COL_W-1:0] tile_column;
		logic [ROW_W-1:0] tile_row;
		logic [7:0]       avg_blue;
		logic [7:0]       avg_green;
		logic [7:0]       avg_red;
		logic             frame_done;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/core/bap_queue.sv
// ----------------------------------------------------------------------------
// bap_queue: short job queue
// Holds finished block sums between the accumulator and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bap_queue
	import bap_pkg::*;
#(
	parameter int DW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	output logic      [DW-1:0] rd_data,
	output logic               q_full,
	output logic               q_empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [DW-1:0] store_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   fill_q;

	assign rd_data = store_q[rd_ptr_q];
	assign q_full  = (fill_q == (PW+1)'(QUEUE_DEPTH));
	assign q_empty = (fill_q == '0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (rd_en) rd_ptr_q <= rd_ptr_q + PW'(1);
			fill_q <= fill_q + (PW+1)'(wr_en) - (PW+1)'(rd_en);
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/bap_front.sv
// ----------------------------------------------------------------------------
// bap_front: raster tracker and per-column accumulator
// Tracks the pixel position, sums each block column in memory, emits jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module bap_front
	import bap_pkg::*;
#(
	parameter int MAX_IMAGE_WIDTH = MAX_IMAGE_WIDTH_DEF,
	parameter int MAX_BLOCK_SIDE  = MAX_BLOCK_SIDE_DEF,
	parameter int XW  = $clog2(MAX_IMAGE_WIDTH),
	parameter int BW  = $clog2(MAX_BLOCK_SIDE),
	parameter int SW  = 8 + 2*BW,
	parameter int CNW = 2*BW + 2,
	parameter int DW  = 1 + ROW_W + COL_W + CNW + 3*SW
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire pix_t          pixel,
	output logic               full,
	input  wire logic [XW-1:0] w_m1,
	input  wire logic [ROW_W-1:0] h_m1,
	input  wire logic [BW-1:0] bw_m1,
	input  wire logic [BW-1:0] bh_m1,
	output logic               job_wr,
	output logic      [DW-1:0] job_data,
	input  wire logic          q_full
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_UPD  = 1'b1;

	logic state_q;
	logic [XW-1:0]    x_q, col_q;
	logic [ROW_W-1:0] y_q, row_q;
	logic [BW-1:0]    xib_q, yib_q;

	pix_t             pix_s1;
	logic [XW-1:0]    col_s1;
	logic [ROW_W-1:0] row_s1;
	logic [BW-1:0]    xib_s1, yib_s1;
	logic             fresh_s1, emit_s1, fdone_s1;

	logic [3*SW-1:0]  mem [MAX_IMAGE_WIDTH];
	logic [3*SW-1:0]  rd_q;
	logic [3*SW-1:0]  new_sums;

	logic accept, row_end, frame_end, bx_end, by_end;
	logic [CNW-1:0] count;

	assign full   = (state_q != S_IDLE) || q_full;
	assign accept = push && !full;

	assign row_end   = (x_q >= w_m1);
	assign frame_end = (y_q >= h_m1);
	assign bx_end    = row_end || (xib_q >= bw_m1);
	assign by_end    = frame_end || (yib_q >= bh_m1);

	always_comb begin
		logic [7:0] p [3];
		p[0] = pix_s1.pixel_red;
		p[1] = pix_s1.pixel_green;
		p[2] = pix_s1.pixel_blue;
		for (int k = 0; k < 3; k++) begin
			if (fresh_s1) new_sums[k*SW +: SW] = SW'(p[k]);
			else          new_sums[k*SW +: SW] = rd_q[k*SW +: SW] + SW'(p[k]);
		end
	end

	assign count = CNW'((CNW'(xib_s1) + CNW'(1)) * (CNW'(yib_s1) + CNW'(1)));

	assign job_wr   = (state_q == S_UPD) && emit_s1;
	assign job_data = {fdone_s1, row_s1, COL_W'(col_s1), count, new_sums};

	// Read the column's sums on accept, write them back in the S_UPD state that follows
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= mem[col_q];
		end
		if (state_q == S_UPD) begin
			mem[col_s1] <= new_sums;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= pixel;
			col_s1   <= col_q;
			row_s1   <= row_q;
			xib_s1   <= xib_q;
			yib_s1   <= yib_q;
			fresh_s1 <= (xib_q == '0) && (yib_q == '0);
			emit_s1  <= bx_end && by_end;
			fdone_s1 <= row_end && frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			x_q     <= '0;
			y_q     <= '0;
			xib_q   <= '0;
			yib_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_UPD;
						if (row_end) begin
							x_q   <= '0;
							xib_q <= '0;
							col_q <= '0;
							if (frame_end) begin
								y_q   <= '0;
								yib_q <= '0;
								row_q <= '0;
							end else begin
								y_q <= y_q + ROW_W'(1);
								if (yib_q >= bh_m1) begin
									yib_q <= '0;
									row_q <= row_q + ROW_W'(1);
								end else begin
									yib_q <= yib_q + BW'(1);
								end
							end
						end else begin
							x_q <= x_q + XW'(1);
							if (xib_q >= bw_m1) begin
								xib_q <= '0;
								col_q <= col_q + XW'(1);
							end else begin
								xib_q <= xib_q + BW'(1);
							end
						end
					end
				end
				S_UPD: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/bap_back.sv
// ----------------------------------------------------------------------------
// bap_back: block mean divider and result register
// Divides three channel sums by the pixel count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bap_back
	import bap_pkg::*;
#(
	parameter int SW  = 24,
	parameter int CNW = 18,
	parameter int DW  = 1 + ROW_W + COL_W + CNW + 3*SW
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [DW-1:0] job_data,
	input  wire logic          q_empty,
	output logic               job_rd,
	output res_t               result,
	output logic               empty,
	input  wire logic          pop
);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_DIV  = 2'd1;
	localparam logic [1:0] B_HOLD = 2'd2;
	localparam int         IW     = $clog2(SW);

	logic [1:0]       state_q;
	logic [IW-1:0]    iter_q;
	logic [SW-1:0]    dq_q  [3];
	logic [CNW-1:0]   rem_q [3];
	logic [CNW-1:0]   cnt_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             fdone_q;
	logic             valid_q;
	res_t             result_q;

	logic [SW-1:0]  dq_nx  [3];
	logic [CNW-1:0] rem_nx [3];
	logic [7:0]     avg    [3];
	logic           slot_free;

	assign job_rd    = (state_q == B_IDLE) && !q_empty;
	assign slot_free = !valid_q || pop;
	assign empty     = !valid_q;
	assign result    = result_q;

	// One restoring step per lane
	always_comb begin
		logic [CNW:0] rs;
		for (int k = 0; k < 3; k++) begin
			rs = {rem_q[k], dq_q[k][SW-1]};
			if (rs >= {1'b0, cnt_q}) begin
				rem_nx[k] = CNW'(rs - {1'b0, cnt_q});
				dq_nx[k]  = {dq_q[k][SW-2:0], 1'b1};
			end else begin
				rem_nx[k] = CNW'(rs);
				dq_nx[k]  = {dq_q[k][SW-2:0], 1'b0};
			end
			avg[k] = (dq_q[k] > SW'(255)) ? 8'hFF : dq_q[k][7:0];
		end
	end

	// Lane 0 carries blue, lane 2 red (the top slice of the job's sums is blue)
	always_ff @(posedge clk) begin
		if (job_rd) begin
			{fdone_q, row_q, col_q, cnt_q, dq_q[0], dq_q[1], dq_q[2]} <= job_data;
			for (int k = 0; k < 3; k++) rem_q[k] <= '0;
		end else if (state_q == B_DIV) begin
			for (int k = 0; k < 3; k++) begin
				dq_q[k]  <= dq_nx[k];
				rem_q[k] <= rem_nx[k];
			end
		end
		if ((state_q == B_HOLD) && slot_free) begin
			result_q.tile_column <= col_q;
			result_q.tile_row    <= row_q;
			result_q.avg_blue    <= avg[0];
			result_q.avg_green   <= avg[1];
			result_q.avg_red     <= avg[2];
			result_q.frame_done  <= fdone_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			iter_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if ((state_q == B_HOLD) && slot_free) valid_q <= 1'b1;
			else if (pop && valid_q)              valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (job_rd) begin
						state_q <= B_DIV;
						iter_q  <= IW'(SW-1);
					end
				end
				B_DIV: begin
					if (iter_q == '0) state_q <= B_HOLD;
					else              iter_q  <= iter_q - IW'(1);
				end
				B_HOLD: begin
					if (slot_free) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/block_average_pixelate_top.sv
// Flow: once a block's last pixel is accepted, its sums go into the job queue; the bit-serial
// divider takes them from there, and the block's mean is registered as the result.
// Flow control: the front takes no new pixel until the last one's column sum is written back;
// the divider takes no new job until its last result is registered; a 4-deep job queue absorbs bursts.
// Reset: arst_n clears positions, queue and registers (640x480 frame, 8x8 blocks); the sum
// memory is not cleared, as every block overwrites its column entry on its first pixel.
// ----------------------------------------------------------------------------
// block_average_pixelate_top: mosaic block-average downsampler
// Tiles a raster pixel stream into blocks and returns each block's mean colour.
// ----------------------------------------------------------------------------
`default_nettype none

module block_average_pixelate_top
	import bap_pkg::*;
#(
	parameter int MAX_IMAGE_WIDTH = MAX_IMAGE_WIDTH_DEF,
	parameter int MAX_BLOCK_SIDE  = MAX_BLOCK_SIDE_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// pixel side: a transfer happens on push with full low
	input  wire logic                  push,
	input  wire pix_t                  pixel,
	output logic                       full,
	// result side: a transfer happens on pop with empty low
	output res_t                       result,
	output logic                       empty,
	input  wire logic                  pop,
	// configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int XW  = $clog2(MAX_IMAGE_WIDTH);
	localparam int BW  = $clog2(MAX_BLOCK_SIDE);
	localparam int SW  = 8 + 2*BW;
	localparam int CNW = 2*BW + 2;
	localparam int DW  = 1 + ROW_W + COL_W + CNW + 3*SW;

	logic [11:0] img_w_q, img_h_q;
	logic [6:0]  blk_w_q, blk_h_q;

	logic [XW-1:0]    w_m1;
	logic [ROW_W-1:0] h_m1;
	logic [BW-1:0]    bw_m1, bh_m1;

	logic          job_wr, job_rd, q_full, q_empty;
	logic [DW-1:0] job_in, job_out;

	// Registers are always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= 12'd640;
			img_h_q <= 12'd480;
			blk_w_q <= 7'd8;
			blk_h_q <= 7'd8;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  img_w_q <= cfg_data;
				CFG_IMAGE_HEIGHT: img_h_q <= cfg_data;
				CFG_BLOCK_WIDTH:  blk_w_q <= cfg_data[6:0];
				CFG_BLOCK_HEIGHT: blk_h_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Clamp each register into its legal range and hand down the last index
	always_comb begin
		logic [31:0] v;
		v = 32'(img_w_q);
		if (v == 32'd0) v = 32'd1;
		if (v > 32'(MAX_IMAGE_WIDTH)) v = 32'(MAX_IMAGE_WIDTH);
		w_m1 = XW'(v - 32'd1);
		v = 32'(img_h_q);
		if (v == 32'd0) v = 32'd1;
		if (v > 32'(MAX_IMAGE_HEIGHT)) v = 32'(MAX_IMAGE_HEIGHT);
		h_m1 = ROW_W'(v - 32'd1);
		v = 32'(blk_w_q);
		if (v == 32'd0) v = 32'd1;
		if (v > 32'(MAX_BLOCK_SIDE)) v = 32'(MAX_BLOCK_SIDE);
		bw_m1 = BW'(v - 32'd1);
		v = 32'(blk_h_q);
		if (v == 32'd0) v = 32'd1;
		if (v > 32'(MAX_BLOCK_SIDE)) v = 32'(MAX_BLOCK_SIDE);
		bh_m1 = BW'(v - 32'd1);
	end

	bap_front #(
		.MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH),
		.MAX_BLOCK_SIDE (MAX_BLOCK_SIDE),
		.XW(XW), .BW(BW), .SW(SW), .CNW(CNW), .DW(DW)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pixel   (pixel),
		.full    (full),
		.w_m1    (w_m1),
		.h_m1    (h_m1),
		.bw_m1   (bw_m1),
		.bh_m1   (bh_m1),
		.job_wr  (job_wr),
		.job_data(job_in),
		.q_full  (q_full)
	);

	// Finished block sums wait here for the divider
	bap_queue #(.DW(DW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_wr),
		.wr_data(job_in),
		.rd_en  (job_rd),
		.rd_data(job_out),
		.q_full (q_full),
		.q_empty(q_empty)
	);

	bap_back #(.SW(SW), .CNW(CNW), .DW(DW)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job_data(job_out),
		.q_empty (q_empty),
		.job_rd  (job_rd),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

`default_nettype wire

>>> tb/bap_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bap_checker: scoreboard of the block-average pixelate core
// Watches the pixel, result and register channels, predicts each block mean
// and compares every popped result with the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module bap_checker
	import bap_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire pix_t                  pixel,
	input  wire logic                  full,
	input  wire res_t                  result,
	input  wire logic                  empty,
	input  wire logic                  pop,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending,
	output int                         block_count
);

	int unsigned reg_img_w, reg_img_h, reg_blk_w, reg_blk_h;
	int unsigned x_pos, y_pos, x_blk, y_blk, tile_col, tile_row;
	int unsigned col_sums [0:MAX_IMAGE_WIDTH_DEF-1][0:2];
	res_t        blocks_due [$];

	function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	// advance the tiling state by one pixel, queue a block mean when one closes
	task automatic accumulate_pixel(input pix_t p);
		int unsigned w, h, bw, bh, col, cnt;
		logic        row_end, frame_end, bx_end, by_end, fresh;
		int unsigned chan [3];
		int unsigned mean [3];
		res_t        r;
		w = clamp(reg_img_w, 1, MAX_IMAGE_WIDTH_DEF);
		h = clamp(reg_img_h, 1, MAX_IMAGE_HEIGHT);
		bw = clamp(reg_blk_w, 1, MAX_BLOCK_SIDE_DEF);
		bh = clamp(reg_blk_h, 1, MAX_BLOCK_SIDE_DEF);
		col = tile_col % MAX_IMAGE_WIDTH_DEF;
		row_end = x_pos >= w - 1;
		frame_end = y_pos >= h - 1;
		bx_end = row_end || x_blk >= bw - 1;
		by_end = frame_end || y_blk >= bh - 1;
		fresh = (x_blk == 0) && (y_blk == 0);
		chan[0] = p.pixel_blue;
		chan[1] = p.pixel_green;
		chan[2] = p.pixel_red;
		for (int k = 0; k < 3; k++) begin
			if (fresh)
				col_sums[col][k] = chan[k];
			else if (col_sums[col][k] <= 32'hFFFF_FF00)
				col_sums[col][k] += chan[k];
		end
		if (bx_end && by_end) begin
			cnt = (x_blk + 1) * (y_blk + 1);
			for (int k = 0; k < 3; k++) begin
				mean[k] = col_sums[col][k] / cnt;
				if (mean[k] > 255)
					mean[k] = 255;
			end
			r.tile_column = tile_col[COL_W-1:0];
			r.tile_row = tile_row[ROW_W-1:0];
			r.avg_blue = mean[0][7:0];
			r.avg_green = mean[1][7:0];
			r.avg_red = mean[2][7:0];
			r.frame_done = row_end && frame_end;
			blocks_due.push_back(r);
		end
		if (row_end) begin
			x_pos = 0;
			x_blk = 0;
			tile_col = 0;
			if (frame_end) begin
				y_pos = 0;
				y_blk = 0;
				tile_row = 0;
			end else begin
				y_pos++;
				if (y_blk >= bh - 1) begin
					y_blk = 0;
					tile_row++;
				end else begin
					y_blk++;
				end
			end
		end else begin
			x_pos++;
			if (x_blk >= bw - 1) begin
				x_blk = 0;
				tile_col++;
			end else begin
				x_blk++;
			end
		end
	endtask

	task automatic report(input string what, input res_t want, input res_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			reg_img_w = 640;
			reg_img_h = 480;
			reg_blk_w = 8;
			reg_blk_h = 8;
			x_pos = 0;
			y_pos = 0;
			x_blk = 0;
			y_blk = 0;
			tile_col = 0;
			tile_row = 0;
			blocks_due.delete();
			fail_count = 0;
			block_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_IMAGE_WIDTH:  reg_img_w = cfg_data;
				CFG_IMAGE_HEIGHT: reg_img_h = cfg_data;
				CFG_BLOCK_WIDTH:  reg_blk_w = cfg_data[6:0];
				CFG_BLOCK_HEIGHT: reg_blk_h = cfg_data[6:0];
				default: ;
				endcase
			end
			if (push && !full)
				accumulate_pixel(pixel);
			if (pop && !empty) begin
				block_count++;
				if (blocks_due.size() == 0) begin
					want = '0;
					report("unexpected result", want, result);
				end else begin
					want = blocks_due.pop_front();
					if (result.tile_column != want.tile_column)
						report("tile_column", want, result);
					if (result.tile_row != want.tile_row)
						report("tile_row", want, result);
					if (result.avg_blue != want.avg_blue)
						report("avg_blue", want, result);
					if (result.avg_green != want.avg_green)
						report("avg_green", want, result);
					if (result.avg_red != want.avg_red)
						report("avg_red", want, result);
					if (result.frame_done != want.frame_done)
						report("frame_done", want, result);
				end
			end
		end
		pending = blocks_due.size();
	end

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the block-average pixelate core
// Streams whole frames under many tilings, register extremes included, with
// random idling on both sides; the checker scores every block mean.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import bap_pkg::*;

	typedef enum int {FILL_RANDOM, FILL_BLACK, FILL_WHITE, FILL_CHECKER} fill_e;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE      = 64;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	pix_t                  pixel;
	logic                  full;
	res_t                  result;
	logic                  empty;
	logic                  pop;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count, pending, block_count;
	int cycles, pixels_sent, frames_sent;
	logic pix_taken, cfg_taken;
	logic quiet;        // set for the closing stretch: no idling on either side
	logic hold_req;     // ask the receiver for a long hold-off

	block_average_pixelate_top uut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .pixel(pixel), .full(full),
		.result(result), .empty(empty), .pop(pop),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bap_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.push(push), .pixel(pixel), .full(full),
		.result(result), .empty(empty), .pop(pop),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .block_count(block_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// register the handshakes so the drivers read them at the falling edge, free of races
	always @(posedge clk) begin
		pix_taken <= push && !full;
		cfg_taken <= cfg_valid && cfg_ready;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off on request, none at the close
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				pop = 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				pop = 1'b0;
				repeat ($urandom_range(0, 11)) @(negedge clk);
			end else begin
				pop = 1'b1;
			end
		end
	end

	// wait for every block mean to drain, then let the divider settle
	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val[CFG_DATA_W-1:0];
		do @(negedge clk); while (!cfg_taken);
		cfg_valid = 1'b0;
	endtask

	// reprogram the tiling; only ever done between whole frames with nothing in flight
	task automatic set_tiling(input int unsigned w, h, bw, bh);
		drain();
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_BLOCK_WIDTH, bw);
		write_reg(CFG_BLOCK_HEIGHT, bh);
	endtask

	task automatic send_pixel(input pix_t p);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			push = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		push = 1'b1;
		pixel = p;
		do @(negedge clk); while (!pix_taken);
		push = 1'b0;
		pixels_sent++;
	endtask

	// one whole frame; pause_at >= 0 holds the sender there until all results are back
	task automatic send_frame(input int unsigned w, h, input fill_e fill, input int pause_at);
		int unsigned ew, eh;
		pix_t p;
		ew = (w < 1) ? 1 : (w > MAX_IMAGE_WIDTH_DEF) ? MAX_IMAGE_WIDTH_DEF : w;
		eh = (h < 1) ? 1 : (h > MAX_IMAGE_HEIGHT) ? MAX_IMAGE_HEIGHT : h;
		for (int i = 0; i < ew * eh; i++) begin
			if (i == pause_at) begin
				while (pending != 0)
					@(negedge clk);
			end
			case (fill)
			FILL_BLACK:   p = '0;
			FILL_WHITE:   p = '1;
			FILL_CHECKER: p = (i % 2) ? pix_t'(24'hFF00FF) : pix_t'(24'h00FF00);
			default:      p = pix_t'(24'($urandom_range(0, 24'hFFFFFF)));
			endcase
			send_pixel(p);
		end
		frames_sent++;
	endtask

	initial begin
		int unsigned w, h, bw, bh;
		fill_e fill;
		arst_n = 1'b0;
		push = 1'b0;
		pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		cycles = 0;
		pixels_sent = 0;
		frames_sent = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: clipped edge blocks at full white, zero registers clamped up,
		// blocks wider and taller than the frame
		set_tiling(5, 3, 2, 2);
		send_frame(5, 3, FILL_WHITE, -1);
		set_tiling(0, 0, 0, 0);
		send_frame(1, 1, FILL_BLACK, -1);
		set_tiling(3, 2, 127, 127);
		send_frame(3, 2, FILL_RANDOM, -1);

		// one block per pixel while the receiver holds off: the queue fills and stalls input
		set_tiling(16, 4, 1, 1);
		hold_req = 1'b1;
		send_frame(16, 4, FILL_CHECKER, -1);

		// register extremes: oversized blocks clamped to the largest side, zero width
		set_tiling(100, 1, 127, 64);
		send_frame(100, 1, FILL_WHITE, -1);
		set_tiling(0, 40, 1, 127);
		send_frame(0, 40, FILL_RANDOM, -1);

		// random tilings, mostly small frames; the last stretch runs without idling
		while (pixels_sent < 1550) begin
			if (pixels_sent > 1250)
				quiet = 1'b1;
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 90) : $urandom_range(1, 24);
			h = $urandom_range(0, 12);
			case ($urandom_range(0, 5))
			0:       begin bw = $urandom_range(0, 127); bh = $urandom_range(0, 127); end
			1:       begin bw = 1; bh = 1; end
			default: begin bw = $urandom_range(1, 9); bh = $urandom_range(1, 9); end
			endcase
			case ($urandom_range(0, 9))
			0:       fill = FILL_BLACK;
			1:       fill = FILL_WHITE;
			2:       fill = FILL_CHECKER;
			default: fill = FILL_RANDOM;
			endcase
			set_tiling(w, h, bw, bh);
			send_frame(w, h, fill, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : -1);
		end

		drain();
		$display("streamed %0d pixels in %0d frames over clamped and clipped tilings,",
			pixels_sent, frames_sent);
		$display("%0d block means scored, output held off and input stalled", block_count);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d failures, %0d results missing", fail_count, pending);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
